// ----- hdl/zffrle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zffrle_pkg
// Shared types and constants of the zero / 0xFF run-length encoder.
// ----------------------------------------------------------------------------
package zffrle_pkg;

   // Width of the emitted-byte counter and of the length limit
   localparam int LengthBits = 16;

   // Depth of the queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   // Most encoded bytes one request can cause
   localparam int MaxBytes = 4;

   // Byte values that form runs
   localparam logic [7:0] ZeroByte = 8'h00;
   localparam logic [7:0] FfByte = 8'hFF;

   // Register index of max_output_length
   localparam logic CsrMaxLenIdx = 1'b0;
   localparam logic [LengthBits-1:0] MaxLenReset = '1;

   // Kind of the pending run
   typedef enum logic [1:0] {
      RunNone = 2'd0,
      RunZero = 2'd1,
      RunFf   = 2'd2
   } run_kind_type;

   // One queue entry: all results that one request causes
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [2:0]               nbytes;
      logic                     status;
      logic                     last;
      logic                     overflow;
      logic [LengthBits-1:0]    block_length;
   } queue_entry_type;

endpackage

// ----- hdl/zffrle_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zffrle request and response channels
// Valid/ready channels carrying raw input bytes and encoded result bytes.
// ----------------------------------------------------------------------------
interface zffrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface zffrle_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        last_of_item;
   logic        end_of_block;
   logic        overflow;
   logic [15:0] block_length;

   modport source(output valid, output out_byte, output byte_valid,
                  output last_of_item, output end_of_block, output overflow,
                  output block_length, input ready);
   modport sink(input valid, input out_byte, input byte_valid,
                input last_of_item, input end_of_block, input overflow,
                input block_length, output ready);
endinterface

// ----- hdl/zero_ff_run_length_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_ff_run_length_encoder
// Run-length encoder for 0x00 and 0xFF bytes with an output length limit.
// ----------------------------------------------------------------------------
// Flow: an accepted request is written into the queue, and the back end
//   then loads its results into the response output register; a request
//   that only extends a run gives no result. One request per cycle while
//   the four-entry queue has room; one result per cycle while rsp is ready.
// Reset (synchronous): clears run state, counters, queue and response valid;
//   max_output_length returns to 65535.
module zero_ff_run_length_encoder (
   input  logic          clock,
   input  logic          reset,
   zffrle_req_if.sink    req_chan,
   zffrle_rsp_if.source  rsp_chan,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   logic [zffrle_pkg::LengthBits-1:0] max_len_ff, max_len_in;
   logic csr_write;
   logic push;
   logic pop;
   logic queue_full;
   logic queue_empty;
   zffrle_pkg::queue_entry_type push_entry;
   zffrle_pkg::queue_entry_type head;

   // Register write and read
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[2] == zffrle_pkg::CsrMaxLenIdx);

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_write) begin
         max_len_in = csr_pwdata[zffrle_pkg::LengthBits-1:0];
      end
      if (csr_paddr[2] == zffrle_pkg::CsrMaxLenIdx) begin
         csr_prdata = 32'(max_len_ff);
      end else begin
         csr_prdata = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= zffrle_pkg::MaxLenReset;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   zffrle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .max_len    (max_len_ff),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   zffrle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   zffrle_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .empty    (queue_empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- hdl/zffrle_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zffrle_front
// Accepts input bytes, tracks the pending run and the output budget, and
// packs every byte a request causes into one queue entry.
// ----------------------------------------------------------------------------
module zffrle_front (
   input  logic                                clock,
   input  logic                                reset,
   zffrle_req_if.sink                          req_chan,
   input  logic [zffrle_pkg::LengthBits-1:0]   max_len,
   input  logic                                queue_full,
   output logic                                push,
   output zffrle_pkg::queue_entry_type         entry
);

   localparam int SumBits = zffrle_pkg::LengthBits + 1;

   zffrle_pkg::run_kind_type run_kind_ff, run_kind_in;
   logic [7:0] run_count_ff, run_count_in;
   logic [zffrle_pkg::LengthBits-1:0] emitted_ff, emitted_in;
   logic aborted_ff, aborted_in;

   logic accept;
   logic is_run;
   zffrle_pkg::run_kind_type kind;
   logic [7:0] pend_marker;
   logic [7:0] byte_b0;
   logic [7:0] cnt_next;
   logic flush_a;
   logic wrap;
   logic unit_b;
   logic [1:0] nb;
   logic [SumBits-1:0] ext_emit;
   logic [SumBits-1:0] ext_lim;
   logic [SumBits-1:0] sum_a;
   logic [SumBits-1:0] sum_b;
   logic [SumBits-1:0] sum_ab;
   logic emit_a;
   logic emit_b;
   logic abort_next;
   logic [zffrle_pkg::LengthBits-1:0] emitted_next;
   logic [2:0] nbytes;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !queue_full;

   // Classify the byte and work out the units it emits
   always_comb begin
      is_run = (req_chan.data_byte == zffrle_pkg::ZeroByte) ||
               (req_chan.data_byte == zffrle_pkg::FfByte);
      kind = (req_chan.data_byte == zffrle_pkg::FfByte) ? zffrle_pkg::RunFf
                                                        : zffrle_pkg::RunZero;
      pend_marker = (run_kind_ff == zffrle_pkg::RunZero) ? zffrle_pkg::ZeroByte
                                                         : zffrle_pkg::FfByte;
      // Old run flushes on a literal or on a change of run kind
      flush_a = !aborted_ff && (run_kind_ff != zffrle_pkg::RunNone) &&
                (!is_run || (run_kind_ff != kind));
      cnt_next = (flush_a ? 8'd0 : run_count_ff) + 8'd1;
      wrap = is_run && (cnt_next == 8'd0);
      // Second unit: literal, wrapped run or final run flush
      unit_b = !aborted_ff && (!is_run || wrap || req_chan.last_byte);
      nb = is_run ? 2'd2 : 2'd1;
      byte_b0 = req_chan.data_byte;

      // Check the budget for each combination in parallel
      ext_emit = {1'b0, emitted_ff};
      ext_lim = {1'b0, max_len};
      sum_a = ext_emit + SumBits'(2);
      sum_b = ext_emit + SumBits'(nb);
      sum_ab = sum_a + SumBits'(nb);
      emit_a = flush_a && (sum_a <= ext_lim);
      emit_b = unit_b && (flush_a ? (emit_a && (sum_ab <= ext_lim))
                                  : (sum_b <= ext_lim));
      abort_next = aborted_ff || (flush_a && !emit_a) || (unit_b && !emit_b);

      if (emit_a && emit_b) begin
         emitted_next = sum_ab[zffrle_pkg::LengthBits-1:0];
      end else if (emit_a) begin
         emitted_next = sum_a[zffrle_pkg::LengthBits-1:0];
      end else if (emit_b) begin
         emitted_next = sum_b[zffrle_pkg::LengthBits-1:0];
      end else begin
         emitted_next = emitted_ff;
      end

      nbytes = (emit_a ? 3'd2 : 3'd0) + (emit_b ? {1'b0, nb} : 3'd0);

      // Pack the entry: old run pair first, then the second unit
      entry = '0;
      if (emit_a) begin
         entry.bytes[0] = pend_marker;
         entry.bytes[1] = run_count_ff;
         entry.bytes[2] = byte_b0;
         entry.bytes[3] = cnt_next;
      end else begin
         entry.bytes[0] = byte_b0;
         entry.bytes[1] = cnt_next;
      end
      entry.nbytes = nbytes;
      entry.last = req_chan.last_byte;
      entry.status = req_chan.last_byte && (abort_next || (nbytes == 3'd0));
      entry.overflow = req_chan.last_byte && abort_next;
      entry.block_length = req_chan.last_byte ? emitted_next : '0;

      push = accept && ((nbytes != 3'd0) || req_chan.last_byte);
   end

   // Advance the run and budget state
   always_comb begin
      run_kind_in = run_kind_ff;
      run_count_in = run_count_ff;
      emitted_in = emitted_ff;
      aborted_in = aborted_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            run_kind_in = zffrle_pkg::RunNone;
            run_count_in = 8'd0;
            emitted_in = '0;
            aborted_in = 1'b0;
         end else begin
            emitted_in = emitted_next;
            aborted_in = abort_next;
            if (!aborted_ff) begin
               if (is_run && !wrap) begin
                  run_kind_in = kind;
                  run_count_in = cnt_next;
               end else begin
                  run_kind_in = zffrle_pkg::RunNone;
                  run_count_in = 8'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff <= zffrle_pkg::RunNone;
         run_count_ff <= 8'd0;
         emitted_ff <= '0;
         aborted_ff <= 1'b0;
      end else begin
         run_kind_ff <= run_kind_in;
         run_count_ff <= run_count_in;
         emitted_ff <= emitted_in;
         aborted_ff <= aborted_in;
      end
   end

   // An aborted block emits no further bytes
   assert property (@(posedge clock) disable iff (reset)
      accept && aborted_ff |-> nbytes == 3'd0)
      else $error("front: byte emitted after abort");

   // Emitted count stays within the limit while not aborted
   assert property (@(posedge clock) disable iff (reset)
      accept && !abort_next |-> emitted_next <= max_len || emitted_next == emitted_ff)
      else $error("front: budget exceeded without abort");

endmodule

// ----- hdl/zffrle_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zffrle_queue
// Short register queue of encoded entries between front and back.
// ----------------------------------------------------------------------------
module zffrle_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  zffrle_pkg::queue_entry_type  push_entry,
   input  logic                         pop,
   output zffrle_pkg::queue_entry_type  head,
   output logic                         full,
   output logic                         empty
);

   zffrle_pkg::queue_entry_type slots_ff [zffrle_pkg::QueueDepth];
   logic [zffrle_pkg::QueuePtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [zffrle_pkg::QueuePtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [zffrle_pkg::QueueCntBits-1:0] count_ff, count_in;

   assign full = (count_ff == zffrle_pkg::QueueCntBits'(zffrle_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign head = slots_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + zffrle_pkg::QueuePtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + zffrle_pkg::QueuePtrBits'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + zffrle_pkg::QueueCntBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - zffrle_pkg::QueueCntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue: push while full");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue: pop while empty");

endmodule

// ----- hdl/zffrle_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zffrle_back
// Walks the head queue entry into the response output register, one result
// per cycle while the output register is free or its result is taken.
// ----------------------------------------------------------------------------
module zffrle_back (
   input  logic                         clock,
   input  logic                         reset,
   input  zffrle_pkg::queue_entry_type  head,
   input  logic                         empty,
   output logic                         pop,
   zffrle_rsp_if.source                 rsp_chan
);

   logic [1:0] sub_ff, sub_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic byte_valid_ff, byte_valid_in;
   logic last_of_item_ff, last_of_item_in;
   logic end_of_block_ff, end_of_block_in;
   logic overflow_ff, overflow_in;
   logic [15:0] block_length_ff, block_length_in;

   logic load;
   logic take;
   logic [2:0] total;
   logic final_res;
   logic is_byte;

   // Pick the current result of the head entry
   always_comb begin
      load = !rsp_valid_ff || rsp_chan.ready;
      take = load && !empty;
      total = head.nbytes + {2'b00, head.status};
      final_res = ({1'b0, sub_ff} == (total - 3'd1));
      is_byte = ({1'b0, sub_ff} < head.nbytes);
      pop = take && final_res;

      sub_in = sub_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      last_of_item_in = last_of_item_ff;
      end_of_block_in = end_of_block_ff;
      overflow_in = overflow_ff;
      block_length_in = block_length_ff;
      if (load) begin
         rsp_valid_in = !empty;
      end
      if (take) begin
         sub_in = final_res ? 2'd0 : sub_ff + 2'd1;
         out_byte_in = is_byte ? head.bytes[sub_ff] : 8'd0;
         byte_valid_in = is_byte;
         last_of_item_in = final_res;
         end_of_block_in = final_res && head.last;
         overflow_in = final_res && head.overflow;
         block_length_in = (final_res && head.last) ? head.block_length : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload in the output register
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_of_item_ff <= last_of_item_in;
      end_of_block_ff <= end_of_block_in;
      overflow_ff <= overflow_in;
      block_length_ff <= block_length_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.byte_valid = byte_valid_ff;
   assign rsp_chan.last_of_item = last_of_item_ff;
   assign rsp_chan.end_of_block = end_of_block_ff;
   assign rsp_chan.overflow = overflow_ff;
   assign rsp_chan.block_length = block_length_ff;

   // Block end always closes the request's results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && end_of_block_ff |-> last_of_item_ff)
      else $error("back: end of block not on last result");

   // Overflow is only flagged at block end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && overflow_ff |-> end_of_block_ff && !byte_valid_ff)
      else $error("back: overflow outside status result");

endmodule

// ----- dv/zffrle_encode_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zffrle_encode_monitor
// Watches the request, response and register ports of the zero / 0xFF
// run-length encoder. It keeps its own copy of the run state and the length
// limit, works out the encoded bytes of every accepted request and compares
// each accepted response with the oldest one still owed.
// ----------------------------------------------------------------------------
module zffrle_encode_monitor (
   input  logic        clock,
   input  logic        reset,
   zffrle_req_if       req_mon,
   zffrle_rsp_if       rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          expected_left,
   output int          request_count,
   output int          result_count,
   output int          block_count,
   output int          abort_count
);

   // One encoded result as it shows on the response channel
   typedef struct packed {
      logic [7:0]                        out_byte;
      logic                              byte_valid;
      logic                              last_of_item;
      logic                              end_of_block;
      logic                              overflow;
      logic [zffrle_pkg::LengthBits-1:0] block_length;
   } enc_result_type;

   // Shadow of the encoder state and its length limit
   logic [zffrle_pkg::LengthBits-1:0] length_limit;
   zffrle_pkg::run_kind_type          run_kind;
   logic [7:0]                        run_count;
   logic [zffrle_pkg::LengthBits-1:0] emitted_count;
   logic                              aborted;

   logic [7:0]            step_bytes[$];
   enc_result_type        owed_results[$];

   int n_mismatch;
   int n_request;
   int n_result;
   int n_block;
   int n_abort;

   // Emit a literal or a run pair whole, or abort the block
   function automatic void emit_unit(input logic [7:0] b0, input logic [7:0] b1,
                                     input int n);
      int unsigned total;
      total = emitted_count + n;
      if (!aborted) begin
         if (total > length_limit) begin
            aborted = 1'b1;
         end else begin
            step_bytes.push_back(b0);
            if (n == 2) step_bytes.push_back(b1);
            emitted_count = emitted_count + zffrle_pkg::LengthBits'(n);
         end
      end
   endfunction

   // Flush the pending run as marker and count
   function automatic void flush_run();
      if (run_kind != zffrle_pkg::RunNone) begin
         emit_unit((run_kind == zffrle_pkg::RunZero) ? zffrle_pkg::ZeroByte
                                                     : zffrle_pkg::FfByte,
                   run_count, 2);
      end
      run_kind = zffrle_pkg::RunNone;
      run_count = '0;
   endfunction

   // Encode one request and queue the results it owes
   function automatic void encode_request(input logic [7:0] b, input logic last);
      zffrle_pkg::run_kind_type kind;
      enc_result_type           r;
      int                       n;
      logic                     status_only;
      step_bytes.delete();
      if (!aborted) begin
         if (b == zffrle_pkg::ZeroByte || b == zffrle_pkg::FfByte) begin
            kind = (b == zffrle_pkg::FfByte) ? zffrle_pkg::RunFf : zffrle_pkg::RunZero;
            if (run_kind != zffrle_pkg::RunNone && run_kind != kind) flush_run();
            run_kind = kind;
            run_count = run_count + 8'd1;
            // a run of 256 wraps to count 0 and goes out at once
            if (run_count == 8'd0) flush_run();
         end else begin
            flush_run();
            emit_unit(b, 8'h00, 1);
         end
      end
      if (last) flush_run();

      n = step_bytes.size();
      status_only = last && (aborted || n == 0);
      for (int k = 0; k < n; k++) begin
         r = '0;
         r.out_byte = step_bytes[k];
         r.byte_valid = 1'b1;
         if (k == n - 1 && !status_only) begin
            r.last_of_item = 1'b1;
            if (last) begin
               r.end_of_block = 1'b1;
               r.block_length = emitted_count;
            end
         end
         owed_results.push_back(r);
      end
      if (status_only) begin
         r = '0;
         r.last_of_item = 1'b1;
         r.end_of_block = 1'b1;
         r.overflow = aborted;
         r.block_length = emitted_count;
         owed_results.push_back(r);
      end

      // clear the block state at block end
      if (last) begin
         run_kind = zffrle_pkg::RunNone;
         run_count = '0;
         emitted_count = '0;
         aborted = 1'b0;
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         n_mismatch++;
      end
   endfunction

   always @(posedge clock) begin : watch
      enc_result_type want;
      if (reset) begin
         length_limit = zffrle_pkg::MaxLenReset;
         run_kind = zffrle_pkg::RunNone;
         run_count = '0;
         emitted_count = '0;
         aborted = 1'b0;
         owed_results.delete();
      end else begin
         // track register writes; other indexes are ignored
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == zffrle_pkg::CsrMaxLenIdx) begin
            length_limit = csr_pwdata[zffrle_pkg::LengthBits-1:0];
         end

         // predict on every accepted request
         if (req_mon.valid && req_mon.ready) begin
            n_request++;
            encode_request(req_mon.data_byte, req_mon.last_byte);
         end

         // compare every accepted response with the oldest owed result
         if (rsp_mon.valid && rsp_mon.ready) begin
            n_result++;
            if (owed_results.size() == 0) begin
               $error("response with nothing owed: out_byte 0x%0h byte_valid %0b",
                      rsp_mon.out_byte, rsp_mon.byte_valid);
               n_mismatch++;
            end else begin
               want = owed_results.pop_front();
               check_field("out_byte", want.out_byte, rsp_mon.out_byte);
               check_field("byte_valid", want.byte_valid, rsp_mon.byte_valid);
               check_field("last_of_item", want.last_of_item, rsp_mon.last_of_item);
               check_field("end_of_block", want.end_of_block, rsp_mon.end_of_block);
               check_field("overflow", want.overflow, rsp_mon.overflow);
               check_field("block_length", want.block_length, rsp_mon.block_length);
               if (want.end_of_block) n_block++;
               if (want.overflow) n_abort++;
            end
         end
      end

      mismatch_count <= n_mismatch;
      expected_left <= owed_results.size();
      request_count <= n_request;
      result_count <= n_result;
      block_count <= n_block;
      abort_count <= n_abort;
   end

endmodule

// ----- dv/zero_ff_run_length_encoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_ff_run_length_encoder_test
// Drives byte blocks into the encoder under a range of length limits, from
// zero up to the largest, with random idling on both channels, a stretch
// without idling and a long response hold-off. The encode monitor checks
// every response; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module zero_ff_run_length_encoder_test;

   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 8;
   localparam int TargetRequests = 470;
   localparam int DirectedRequests = 25;
   localparam int LongRunRequests = 258;
   localparam int LongHold = 300;
   localparam int NumPhases = 8;
   localparam logic [2:0] MaxLenAddr = 3'd0;
   localparam logic [2:0] UnusedAddr = 3'd4;
   localparam logic [zffrle_pkg::LengthBits-1:0] LimitPlan [NumPhases] =
      '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd6, 16'd24, 16'hFFFF};

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int expected_left;
   int request_count;
   int result_count;
   int block_count;
   int abort_count;

   int   cycle_count = 0;
   int   hold_cycles = 0;
   logic hold_start = 1'b0;
   logic hold_done = 1'b0;
   logic quiet = 1'b0;
   int   random_sent = 0;

   zffrle_req_if req_if();
   zffrle_rsp_if rsp_if();

   zero_ff_run_length_encoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if.sink),
      .rsp_chan    (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   zffrle_encode_monitor encode_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left),
      .request_count  (request_count),
      .result_count   (result_count),
      .block_count    (block_count),
      .abort_count    (abort_count)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $error("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Idle with odds of 9 in a hundred unless a quiet stretch is on
   function automatic logic gap_roll();
      return !quiet && ($urandom_range(99) < 9);
   endfunction

   // Response side: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_start && !hold_done) begin
         rsp_if.ready <= 1'b0;
         hold_cycles <= LongHold;
         hold_done <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_if.ready <= !gap_roll();
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (gap_roll()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every owed result is out
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Setup and access cycle of a register write
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // One block of runs and literals with random content
   task automatic send_random_block(input int span);
      int         left;
      int         seg;
      int         pick;
      logic [7:0] b;
      left = span;
      while (left > 0) begin
         pick = $urandom_range(99);
         seg = $urandom_range(1, 5);
         if (seg > left) seg = left;
         for (int i = 0; i < seg; i++) begin
            if (pick < 35) b = zffrle_pkg::ZeroByte;
            else if (pick < 70) b = zffrle_pkg::FfByte;
            else b = 8'($urandom_range(255));
            send_byte(b, left == 1);
            left--;
         end
      end
      random_sent += span;
   endtask

   initial begin : stimulus
      int         quota;
      int         run_len;
      logic [7:0] run_byte;

      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single zero byte closing a block
      send_byte(zffrle_pkg::ZeroByte, 1'b1);
      // run kind change, literals on both sides of the midpoint of the range
      send_byte(zffrle_pkg::FfByte, 1'b0);
      send_byte(zffrle_pkg::FfByte, 1'b0);
      send_byte(zffrle_pkg::ZeroByte, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      // kind change on the last byte: two run pairs from one request
      send_byte(zffrle_pkg::ZeroByte, 1'b0);
      send_byte(zffrle_pkg::FfByte, 1'b1);
      wait_idle();

      // write to an unused index leaves the limit alone
      csr_write(UnusedAddr, 32'h0000_0001);
      send_byte(zffrle_pkg::ZeroByte, 1'b0);
      send_byte(8'h01, 1'b1);
      wait_idle();

      // zero limit: everything overflows
      csr_write(MaxLenAddr, 32'd0);
      send_byte(8'h12, 1'b1);
      send_byte(zffrle_pkg::ZeroByte, 1'b1);
      wait_idle();

      // pair fits, the following literal or pair does not
      csr_write(MaxLenAddr, 32'd2);
      send_byte(zffrle_pkg::ZeroByte, 1'b0);
      send_byte(8'h33, 1'b1);
      send_byte(zffrle_pkg::ZeroByte, 1'b0);
      send_byte(zffrle_pkg::FfByte, 1'b1);
      wait_idle();

      // exactly at the limit, then drop the rest of an aborted block
      csr_write(MaxLenAddr, 32'd3);
      send_byte(8'h7E, 1'b0);
      send_byte(zffrle_pkg::ZeroByte, 1'b0);
      send_byte(zffrle_pkg::ZeroByte, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hFD, 1'b1);
      wait_idle();

      // random blocks under each limit setting
      for (int p = 0; p < NumPhases; p++) begin
         csr_write(MaxLenAddr, 32'(LimitPlan[p]));
         quiet = (p == 0);
         if (p == NumPhases - 2) hold_start = 1'b1;
         if (p == NumPhases - 1) begin
            // a run long enough to wrap the count, closed by a literal
            run_len = $urandom_range(256, 260);
            run_byte = $urandom_range(1) ? zffrle_pkg::FfByte : zffrle_pkg::ZeroByte;
            for (int i = 0; i < run_len; i++) send_byte(run_byte, 1'b0);
            send_byte(8'h5A, 1'b1);
         end
         quota = ((p + 1) * (TargetRequests - LongRunRequests - DirectedRequests)) /
                 NumPhases;
         do begin
            send_random_block($urandom_range(1, 12));
         end while (random_sent < quota);
         wait_idle();
      end
      quiet = 1'b0;

      $display("Ran %0d requests in %0d blocks, %0d of them aborted on the length limit.",
               request_count, block_count, abort_count);
      $display("Checked %0d responses across limits from 0 to 65535, with a wrapped run.",
               result_count);
      if (mismatch_count == 0 && expected_left == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
